FILE: rtl/hrl_pkg.sv
`default_nettype none
package hrl_pkg;

  localparam int PRIME_BITS = 32;
  localparam logic [31:0] PRIME_MASK = 32'((64'd1 << PRIME_BITS) - 64'd1);

  localparam logic [3:0] DEGREE_RESET = 4'd6;
  localparam logic [0:0] REG_DEGREE = 1'b0;

  typedef enum logic [4:0] {
    S_IDLE,
    S_PP,
    S_RR,
    S_NV,
    S_M0,
    S_POW,
    S_RD,
    S_PWP,
    S_DP,
    S_DER,
    S_NEG,
    S_EQ,
    S_EU,
    S_EF,
    S_DIFF,
    S_LAM,
    S_CORR,
    S_CP,
    S_RES1,
    S_RES2,
    S_DONE
  } state_t;

  function automatic logic [63:0] add_mod(input logic [63:0] a, input logic [63:0] b,
                                          input logic [63:0] m);
    logic [64:0] s;
    logic [64:0] d;
    s = {1'b0, a} + {1'b0, b};
    d = s - {1'b0, m};
    add_mod = (s >= {1'b0, m}) ? d[63:0] : s[63:0];
  endfunction

endpackage
`default_nettype wire

FILE: rtl/hensel_root_lift_mod_p2.sv
// Work per word: up to degree+2 modular multiplies (degree-1 for the power), five wide
// divisions, short divisions and Euclid steps (up to about 46 steps), all on bit-serial units.
// Throughput: one word at a time, set by the shared bit-serial multiply and divide units.
// A zero root or a zero prime goes from accept straight to the result state S_DONE.
// Reset: synchronous active-low rst_n clears control state; degree returns to 6.
`default_nettype none
module hensel_root_lift_mod_p2 (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [31:0] in_root_mod_p,
  input  wire logic [31:0] in_prime,
  input  wire logic [63:0] in_target_mod_p2,
  input  wire logic [63:0] in_offset_mod_p2,
  input  wire logic        in_last_root,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [63:0]      out_lifted_root,
  output logic             out_kept,
  output logic             out_singular,
  output logic             out_last_out,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  hrl_pkg::state_t state_r, state_nxt;
  logic phase_r, phase_nxt;
  logic mstart, dstart, dshort;
  logic op_end;

  logic [3:0]  deg_r;
  logic [31:0] r_r, p_r;
  logic [63:0] nv_r, m0_r;
  logic        last_r, kept_r, sing_r;
  logic [63:0] pp_r, rr_r, nvr_r, m0r_r, pw_r, rd_r;
  logic [3:0]  ecnt_r;
  logic [31:0] pwp_r, dp_r, der_r, oldr_r, curr_r, q_r, t_r, inv_r, lam_r;
  logic signed [32:0] olds_r, curs_r;
  logic [63:0] negrd_r, negm0_r, diff_r, corr_r, res_r;
  logic        out_valid_r;
  logic [63:0] out_root_r;
  logic        out_kept_r, out_sing_r, out_last_r;

  // multiply-mod unit
  logic [63:0] ma_r, mb_r, mm_r, macc_r;
  logic [5:0]  mbit_r;
  logic        mph_r, mbusy_r;
  logic [63:0] ms_a, ms_b, ms_m;

  // divide unit
  logic [63:0] dx_r, dd_r, drem_r, dquo_r;
  logic [5:0]  dcnt_r;
  logic        dbusy_r;
  logic [63:0] ds_x, ds_d;
  logic [64:0] dtrial;
  logic        dge;

  // shared add-mod and multiplier
  logic [63:0] au_a, au_b, au_m, au_y;
  logic signed [32:0] mx_a, mx_b;
  logic signed [65:0] mx_p;
  logic signed [65:0] s_upd;
  logic [33:0] inv_sum;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == hrl_pkg::REG_DEGREE) ? {28'd0, deg_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      deg_r <= hrl_pkg::DEGREE_RESET;
    end else if (psel && penable && pwrite && paddr[2] == hrl_pkg::REG_DEGREE) begin
      deg_r <= pwdata[3:0];
    end
  end

  assign in_ready = (state_r == hrl_pkg::S_IDLE);
  assign out_valid = out_valid_r;
  assign out_lifted_root = out_root_r;
  assign out_kept = out_kept_r;
  assign out_singular = out_sing_r;
  assign out_last_out = out_last_r;
  assign op_end = phase_r && !mbusy_r && !dbusy_r;

  always_comb begin
    au_a = macc_r;
    au_b = mph_r ? ma_r : macc_r;
    au_m = mm_r;
    if (!mbusy_r) begin
      case (state_r)
        hrl_pkg::S_DIFF: begin
          au_a = nvr_r; au_b = negrd_r; au_m = pp_r;
        end
        hrl_pkg::S_RES1: begin
          au_a = rr_r; au_b = corr_r; au_m = pp_r;
        end
        default: begin
          au_a = res_r; au_b = negm0_r; au_m = pp_r;
        end
      endcase
    end
  end
  assign au_y = hrl_pkg::add_mod(au_a, au_b, au_m);

  always_comb begin
    case (state_r)
      hrl_pkg::S_EU: begin
        mx_a = $signed({1'b0, q_r}); mx_b = curs_r;
      end
      hrl_pkg::S_CP: begin
        mx_a = $signed({1'b0, t_r}); mx_b = $signed({1'b0, p_r});
      end
      default: begin
        mx_a = $signed({1'b0, p_r}); mx_b = $signed({1'b0, p_r});
      end
    endcase
  end
  assign mx_p = mx_a * mx_b;
  assign s_upd = 66'(olds_r) - mx_p;
  assign inv_sum = {olds_r[32], olds_r} + (olds_r[32] ? {2'b00, p_r} : 34'd0);

  always_comb begin
    ms_a = pw_r; ms_b = rr_r; ms_m = pp_r;
    case (state_r)
      hrl_pkg::S_DER: begin
        ms_a = {32'd0, pwp_r}; ms_b = {32'd0, dp_r}; ms_m = {32'd0, p_r};
      end
      hrl_pkg::S_CORR: begin
        ms_a = {32'd0, lam_r}; ms_b = {32'd0, inv_r}; ms_m = {32'd0, p_r};
      end
      default: begin
        ms_a = pw_r; ms_b = rr_r; ms_m = pp_r;
      end
    endcase
  end

  always_comb begin
    ds_x = {32'd0, r_r}; ds_d = pp_r; dshort = 1'b0;
    case (state_r)
      hrl_pkg::S_NV: ds_x = nv_r;
      hrl_pkg::S_M0: ds_x = m0_r;
      hrl_pkg::S_PWP: begin
        ds_x = pw_r; ds_d = {32'd0, p_r};
      end
      hrl_pkg::S_DP: begin
        ds_x = {60'd0, deg_r}; ds_d = {32'd0, p_r}; dshort = 1'b1;
      end
      hrl_pkg::S_EQ: begin
        ds_x = {32'd0, oldr_r}; ds_d = {32'd0, curr_r}; dshort = 1'b1;
      end
      hrl_pkg::S_LAM: begin
        ds_x = diff_r; ds_d = {32'd0, p_r};
      end
      default: begin
        ds_x = {32'd0, r_r}; ds_d = pp_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mbusy_r <= 1'b0;
    end else if (mstart) begin
      mbusy_r <= 1'b1;
    end else if (mbusy_r && mph_r && mbit_r == 6'd0) begin
      mbusy_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (mstart) begin
      ma_r <= ms_a; mb_r <= ms_b; mm_r <= ms_m;
      macc_r <= 64'd0; mbit_r <= 6'd63; mph_r <= 1'b0;
    end else if (mbusy_r) begin
      if (!mph_r) begin
        macc_r <= au_y;
        mph_r <= 1'b1;
      end else begin
        if (mb_r[mbit_r]) begin
          macc_r <= au_y;
        end
        mbit_r <= mbit_r - 6'd1;
        mph_r <= 1'b0;
      end
    end
  end

  assign dtrial = {drem_r, dx_r[63]};
  assign dge = dtrial >= {1'b0, dd_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dbusy_r <= 1'b0;
    end else if (dstart) begin
      dbusy_r <= 1'b1;
    end else if (dbusy_r && dcnt_r == 6'd0) begin
      dbusy_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (dstart) begin
      dx_r <= dshort ? {ds_x[31:0], 32'd0} : ds_x;
      dd_r <= ds_d;
      drem_r <= 64'd0;
      dquo_r <= 64'd0;
      dcnt_r <= dshort ? 6'd31 : 6'd63;
    end else if (dbusy_r) begin
      dx_r <= {dx_r[62:0], 1'b0};
      drem_r <= dge ? 64'(dtrial - {1'b0, dd_r}) : dtrial[63:0];
      dquo_r <= {dquo_r[62:0], dge};
      dcnt_r <= dcnt_r - 6'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= hrl_pkg::S_IDLE;
      phase_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      phase_r <= phase_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    phase_nxt = phase_r;
    mstart = 1'b0;
    dstart = 1'b0;
    case (state_r)
      hrl_pkg::S_IDLE: begin
        if (in_valid) begin
          if (in_root_mod_p == 32'd0 || (in_prime & hrl_pkg::PRIME_MASK) == 32'd0) begin
            state_nxt = hrl_pkg::S_DONE;
          end else begin
            state_nxt = hrl_pkg::S_PP;
          end
        end
      end
      hrl_pkg::S_PP: state_nxt = hrl_pkg::S_RR;
      hrl_pkg::S_RR, hrl_pkg::S_NV, hrl_pkg::S_M0, hrl_pkg::S_PWP, hrl_pkg::S_DP,
      hrl_pkg::S_EQ, hrl_pkg::S_LAM: begin
        if (!phase_r) begin
          dstart = 1'b1;
          phase_nxt = 1'b1;
        end else if (op_end) begin
          phase_nxt = 1'b0;
          case (state_r)
            hrl_pkg::S_RR: state_nxt = hrl_pkg::S_NV;
            hrl_pkg::S_NV: state_nxt = hrl_pkg::S_M0;
            hrl_pkg::S_M0: state_nxt = hrl_pkg::S_POW;
            hrl_pkg::S_PWP: state_nxt = hrl_pkg::S_DP;
            hrl_pkg::S_DP: state_nxt = hrl_pkg::S_DER;
            hrl_pkg::S_EQ: state_nxt = hrl_pkg::S_EU;
            default: state_nxt = hrl_pkg::S_CORR;
          endcase
        end
      end
      hrl_pkg::S_POW: begin
        if (!phase_r) begin
          if (deg_r == 4'd0 || ecnt_r == 4'd0) begin
            state_nxt = hrl_pkg::S_RD;
          end else begin
            mstart = 1'b1;
            phase_nxt = 1'b1;
          end
        end else if (op_end) begin
          phase_nxt = 1'b0;
        end
      end
      hrl_pkg::S_RD: begin
        if (!phase_r) begin
          if (deg_r == 4'd0) begin
            state_nxt = hrl_pkg::S_NEG;
          end else begin
            mstart = 1'b1;
            phase_nxt = 1'b1;
          end
        end else if (op_end) begin
          phase_nxt = 1'b0;
          state_nxt = hrl_pkg::S_PWP;
        end
      end
      hrl_pkg::S_DER: begin
        if (!phase_r) begin
          mstart = 1'b1;
          phase_nxt = 1'b1;
        end else if (op_end) begin
          phase_nxt = 1'b0;
          state_nxt = hrl_pkg::S_NEG;
        end
      end
      hrl_pkg::S_NEG: state_nxt = (der_r == 32'd0) ? hrl_pkg::S_DIFF : hrl_pkg::S_EQ;
      hrl_pkg::S_EU: state_nxt = (t_r == 32'd0) ? hrl_pkg::S_EF : hrl_pkg::S_EQ;
      hrl_pkg::S_EF: state_nxt = hrl_pkg::S_DIFF;
      hrl_pkg::S_DIFF: state_nxt = hrl_pkg::S_LAM;
      hrl_pkg::S_CORR: begin
        if (!phase_r) begin
          if (sing_r) begin
            state_nxt = hrl_pkg::S_RES1;
          end else begin
            mstart = 1'b1;
            phase_nxt = 1'b1;
          end
        end else if (op_end) begin
          phase_nxt = 1'b0;
          state_nxt = hrl_pkg::S_CP;
        end
      end
      hrl_pkg::S_CP: state_nxt = hrl_pkg::S_RES1;
      hrl_pkg::S_RES1: state_nxt = hrl_pkg::S_RES2;
      hrl_pkg::S_RES2: state_nxt = hrl_pkg::S_DONE;
      hrl_pkg::S_DONE: begin
        if (!out_valid_r || out_ready) begin
          state_nxt = hrl_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = hrl_pkg::S_IDLE;
        phase_nxt = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    case (state_r)
      hrl_pkg::S_IDLE: begin
        if (in_valid) begin
          r_r <= in_root_mod_p;
          p_r <= in_prime & hrl_pkg::PRIME_MASK;
          nv_r <= in_target_mod_p2;
          m0_r <= in_offset_mod_p2;
          last_r <= in_last_root;
          kept_r <= (in_root_mod_p != 32'd0);
          sing_r <= (in_root_mod_p != 32'd0);
          res_r <= 64'd0;
          if (in_root_mod_p != 32'd0 && (in_prime & hrl_pkg::PRIME_MASK) != 32'd0) begin
            sing_r <= 1'b0;
          end
        end
      end
      hrl_pkg::S_PP: pp_r <= mx_p[63:0];
      hrl_pkg::S_RR: if (op_end) rr_r <= drem_r;
      hrl_pkg::S_NV: if (op_end) nvr_r <= drem_r;
      hrl_pkg::S_M0: begin
        if (op_end) begin
          m0r_r <= drem_r;
          pw_r <= (pp_r == 64'd1) ? 64'd0 : 64'd1;
          ecnt_r <= deg_r - 4'd1;
        end
      end
      hrl_pkg::S_POW: begin
        if (op_end) begin
          pw_r <= macc_r;
          ecnt_r <= ecnt_r - 4'd1;
        end
      end
      hrl_pkg::S_RD: begin
        if (!phase_r && deg_r == 4'd0) begin
          rd_r <= pw_r;
          der_r <= 32'd0;
        end else if (op_end) begin
          rd_r <= macc_r;
        end
      end
      hrl_pkg::S_PWP: if (op_end) pwp_r <= drem_r[31:0];
      hrl_pkg::S_DP: if (op_end) dp_r <= drem_r[31:0];
      hrl_pkg::S_DER: if (op_end) der_r <= macc_r[31:0];
      hrl_pkg::S_NEG: begin
        negrd_r <= (rd_r == 64'd0) ? 64'd0 : pp_r - rd_r;
        negm0_r <= (m0r_r == 64'd0) ? 64'd0 : pp_r - m0r_r;
        oldr_r <= p_r;
        curr_r <= der_r;
        olds_r <= 33'sd0;
        curs_r <= 33'sd1;
        sing_r <= (der_r == 32'd0);
      end
      hrl_pkg::S_EQ: begin
        if (op_end) begin
          q_r <= dquo_r[31:0];
          t_r <= drem_r[31:0];
        end
      end
      hrl_pkg::S_EU: begin
        olds_r <= curs_r;
        curs_r <= s_upd[32:0];
        oldr_r <= curr_r;
        curr_r <= t_r;
      end
      hrl_pkg::S_EF: begin
        sing_r <= (oldr_r != 32'd1);
        inv_r <= (inv_sum[31:0] >= p_r) ? inv_sum[31:0] - p_r : inv_sum[31:0];
      end
      hrl_pkg::S_DIFF: diff_r <= au_y;
      hrl_pkg::S_LAM: if (op_end) lam_r <= dquo_r[31:0];
      hrl_pkg::S_CORR: begin
        if (!phase_r && sing_r) begin
          corr_r <= 64'd0;
        end else if (op_end) begin
          t_r <= macc_r[31:0];
        end
      end
      hrl_pkg::S_CP: corr_r <= mx_p[63:0];
      hrl_pkg::S_RES1: res_r <= au_y;
      hrl_pkg::S_RES2: res_r <= au_y;
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == hrl_pkg::S_DONE && (!out_valid_r || out_ready)) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == hrl_pkg::S_DONE && (!out_valid_r || out_ready)) begin
      out_root_r <= res_r;
      out_kept_r <= kept_r;
      out_sing_r <= sing_r;
      out_last_r <= last_r;
    end
  end

`ifndef SYNTHESIS
  a_units_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    !(mbusy_r && dbusy_r))
    else $error("multiply and divide units busy together");

  a_zero_root_fast: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && in_root_mod_p == 32'd0) |=>
      (state_r == hrl_pkg::S_DONE && !kept_r))
    else $error("zero root not sent straight to result");

  a_dropped_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_kept) |-> (out_lifted_root == 64'd0 && !out_singular))
    else $error("dropped root carries nonzero fields");
`endif

endmodule
`default_nettype wire
